[sv/pcks_pkg.sv]
// Shared types, codes and helpers for the particle cell key sort core.
// Depends on nothing; used by the core and its port checker.
`default_nettype none
package pcks_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = AddrW + 1;

  localparam logic [31:0] InvCellReset  = 32'd65536;
  localparam logic [15:0] GridRowsReset = 16'd1;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_READ   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_RANK = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_INV_CELL  = 1'b0,
    REG_GRID_ROWS = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_K,
    S_WR_LD,
    S_CMP_RD,
    S_CMP_WR,
    S_SORT_I,
    S_SORT_HOLD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_RANK_RD,
    S_SRCH,
    S_SRCH_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               dis;
    logic [AddrW-1:0]   order;
    logic signed [15:0] xidx;
    logic signed [31:0] key;
  } entry_t;

  // Round half up and truncate toward zero, then saturate to 16 bits.
  function automatic logic signed [15:0] cell_axis(input logic signed [65:0] prod);
    logic signed [66:0] v;
    logic [66:0]        nv;
    logic [34:0]        q;
    logic signed [15:0] r;
    v = {prod[65], prod} + 67'sd2147483648;
    nv = 67'd0 - v;
    if (!v[66]) begin
      q = v[66:32];
      r = (q > 35'd32767) ? 16'sd32767 : q[15:0];
    end else begin
      q = nv[66:32];
      r = (q > 35'd32768) ? -16'sd32768 : 16'(-q[15:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/particle_cell_key_sort_core.sv]
// Particle cell key sort core: loads particles, filters and sorts them by cell key,
// answers rank reads and x index searches. Depends on pcks_pkg.
//
// Usage:
//  - Input channel s_axis_*: tuser carries the mode (load, finish, read rank, search),
//    tdata carries pos_x, pos_y, utility_word, rank and query_x_index.
//  - Output channel m_axis_*: one beat for every input beat; tuser is the status,
//    tdata holds survivor_count, original_index, cell_key and first_rank.
//  - Configuration: cfg_we_i writes inverse_cell_size (index 0) or grid_rows (index 1).
//  - Load uses one shared multiplier three times; a load into a full table and a read
//    of an out-of-range rank go straight to the result. Search is a binary search with
//    at most ceil(log2(count+1)) iterations; finish compacts the L loaded entries to the
//    n kept ones and insertion-sorts them by cell key.
//  - One item at a time: s_axis_tready is high only while the sequencer is idle. The
//    next item is taken while a finished result still waits in the output register.
//  - Reset clears counts and handshake state and restores the config defaults; table
//    contents are only meaningful below the loaded count, so the memory is never cleared.
//  - A stalled receiver holds the output beat; the sequencer waits in its final state.
`default_nettype none
module particle_cell_key_sort_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [31:0] pos_x, [63:32] pos_y, [127:64] utility_word, [137:128] rank,
  // [153:138] query_x_index, [159:154] zero
  input  wire logic [159:0] s_axis_tdata_i,
  // [1:0] mode
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [10:0] survivor_count, [20:11] original_index, [52:21] cell_key, [63:53] first_rank
  output logic [63:0]       m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]        m_axis_tuser_o,
  input  wire logic         cfg_we_i,
  input  wire logic [0:0]   cfg_addr_i,
  input  wire logic [31:0]  cfg_wdata_i
);

  localparam int unsigned AW = pcks_pkg::AddrW;
  localparam int unsigned CW = pcks_pkg::CountW;

  pcks_pkg::state_e state_q, state_d;

  logic [31:0] inv_q;
  logic [15:0] rows_q;

  // latched item
  pcks_pkg::mode_e    mode_q;
  logic signed [31:0] px_q, py_q;
  logic               dis_q;
  logic [AW-1:0]      rank_q;
  logic signed [15:0] qx_q;

  logic signed [65:0] prod_q;
  logic signed [15:0] xi_q, yi_q;

  logic [CW-1:0] loaded_q, kept_q;
  logic [CW-1:0] idx_q, idx_d;   // compaction read index / sort outer index
  logic [CW-1:0] cnt_q, cnt_d;   // compaction write count
  logic [CW-1:0] j_q, j_d;       // insertion slot
  logic [CW-1:0] first_q, first_d, len_q, len_d;
  pcks_pkg::entry_t hold_q;

  // result being built
  pcks_pkg::status_e res_stat_q, res_stat_d;
  logic [AW-1:0]     res_orig_q, res_orig_d;
  logic [31:0]       res_key_q, res_key_d;
  logic [CW-1:0]     res_first_q, res_first_d;

  logic out_valid_q;
  logic [63:0] out_data_q;
  logic [1:0]  out_user_q;

  // shared table memory
  pcks_pkg::entry_t mem [pcks_pkg::Capacity];
  pcks_pkg::entry_t rd_q, wr_data;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [CW-1:0]      mid;
  logic               in_acc, out_free;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign mid      = first_q + (len_q >> 1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // shared multiplier: position times inverse size, then x index times rows
  always_comb begin
    mul_a = {px_q[31], px_q};
    mul_b = {1'b0, inv_q};
    case (state_q)
      pcks_pkg::S_MUL_Y: mul_a = {py_q[31], py_q};
      pcks_pkg::S_MUL_K: begin
        mul_a = 33'(xi_q);
        mul_b = {17'd0, rows_q};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcks_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          case (pcks_pkg::mode_e'(s_axis_tuser_i))
            pcks_pkg::MODE_LOAD:
              state_d = (loaded_q == CW'(pcks_pkg::Capacity)) ? pcks_pkg::S_DONE
                                                               : pcks_pkg::S_MUL_X;
            pcks_pkg::MODE_FINISH: state_d = pcks_pkg::S_CMP_RD;
            pcks_pkg::MODE_READ:
              state_d = ({1'b0, s_axis_tdata_i[137:128]} < kept_q) ? pcks_pkg::S_RANK_RD
                                                                    : pcks_pkg::S_DONE;
            default: state_d = pcks_pkg::S_SRCH;
          endcase
        end
      end
      pcks_pkg::S_MUL_X:   state_d = pcks_pkg::S_MUL_Y;
      pcks_pkg::S_MUL_Y:   state_d = pcks_pkg::S_MUL_K;
      pcks_pkg::S_MUL_K:   state_d = pcks_pkg::S_WR_LD;
      pcks_pkg::S_WR_LD:   state_d = pcks_pkg::S_DONE;
      pcks_pkg::S_CMP_RD:
        state_d = (idx_q == loaded_q) ? pcks_pkg::S_SORT_I : pcks_pkg::S_CMP_WR;
      pcks_pkg::S_CMP_WR:  state_d = pcks_pkg::S_CMP_RD;
      pcks_pkg::S_SORT_I:
        state_d = (idx_q >= cnt_q) ? pcks_pkg::S_DONE : pcks_pkg::S_SORT_HOLD;
      pcks_pkg::S_SORT_HOLD: state_d = pcks_pkg::S_SORT_CMP;
      pcks_pkg::S_SORT_CMP: begin
        if ($signed(rd_q.key) > $signed(hold_q.key)) begin
          if (j_q == CW'(1)) state_d = pcks_pkg::S_SORT_PUT;
        end else begin
          state_d = pcks_pkg::S_SORT_I;
        end
      end
      pcks_pkg::S_SORT_PUT: state_d = pcks_pkg::S_SORT_I;
      pcks_pkg::S_RANK_RD:  state_d = pcks_pkg::S_DONE;
      pcks_pkg::S_SRCH:
        state_d = (len_q == '0) ? pcks_pkg::S_DONE : pcks_pkg::S_SRCH_CMP;
      pcks_pkg::S_SRCH_CMP: state_d = pcks_pkg::S_SRCH;
      pcks_pkg::S_DONE:     if (out_free) state_d = pcks_pkg::S_IDLE;
      default:              state_d = pcks_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    s_axis_tready_o = (state_q == pcks_pkg::S_IDLE);
    rd_addr     = idx_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = cnt_q[AW-1:0];
    wr_data     = rd_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    first_d     = first_q;
    len_d       = len_q;
    res_stat_d  = res_stat_q;
    res_orig_d  = res_orig_q;
    res_key_d   = res_key_q;
    res_first_d = res_first_q;
    case (state_q)
      pcks_pkg::S_IDLE: begin
        idx_d       = '0;
        cnt_d       = '0;
        first_d     = '0;
        len_d       = kept_q;
        res_stat_d  = pcks_pkg::STAT_OK;
        res_orig_d  = '0;
        res_key_d   = '0;
        res_first_d = '0;
        if (pcks_pkg::mode_e'(s_axis_tuser_i) == pcks_pkg::MODE_LOAD &&
            loaded_q == CW'(pcks_pkg::Capacity)) begin
          res_stat_d = pcks_pkg::STAT_FULL;
        end
        if (pcks_pkg::mode_e'(s_axis_tuser_i) == pcks_pkg::MODE_READ &&
            !({1'b0, s_axis_tdata_i[137:128]} < kept_q)) begin
          res_stat_d = pcks_pkg::STAT_BAD_RANK;
        end
      end
      pcks_pkg::S_WR_LD: begin
        wr_en         = 1'b1;
        wr_addr       = loaded_q[AW-1:0];
        wr_data.key   = prod_q[31:0] + 32'(yi_q);
        wr_data.xidx  = xi_q;
        wr_data.order = loaded_q[AW-1:0];
        wr_data.dis   = dis_q;
      end
      pcks_pkg::S_CMP_RD: begin
        if (idx_q == loaded_q) idx_d = CW'(1);
      end
      pcks_pkg::S_CMP_WR: begin
        idx_d = idx_q + 1'b1;
        if (!rd_q.dis) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      pcks_pkg::S_SORT_HOLD: begin
        rd_addr = AW'(idx_q - 1'b1);
        j_d     = idx_q;
      end
      pcks_pkg::S_SORT_CMP: begin
        wr_en   = 1'b1;
        wr_addr = j_q[AW-1:0];
        if ($signed(rd_q.key) > $signed(hold_q.key)) begin
          j_d     = j_q - 1'b1;
          rd_addr = AW'(j_q - CW'(2));
        end else begin
          wr_data = hold_q;
          idx_d   = idx_q + 1'b1;
        end
      end
      pcks_pkg::S_SORT_PUT: begin
        wr_en   = 1'b1;
        wr_addr = j_q[AW-1:0];
        wr_data = hold_q;
        idx_d   = idx_q + 1'b1;
      end
      pcks_pkg::S_RANK_RD: rd_addr = rank_q;
      pcks_pkg::S_SRCH: begin
        rd_addr = mid[AW-1:0];
        if (len_q == '0) res_first_d = first_q;
      end
      pcks_pkg::S_SRCH_CMP: begin
        rd_addr = mid[AW-1:0];
        if (rd_q.xidx < qx_q) begin
          first_d = mid + 1'b1;
          len_d   = len_q - (len_q >> 1) - 1'b1;
        end else begin
          len_d = len_q >> 1;
        end
      end
      pcks_pkg::S_DONE: begin
        // keep the ranked entry on the read port while the receiver stalls
        rd_addr = rank_q;
        if (mode_q == pcks_pkg::MODE_READ && res_stat_q == pcks_pkg::STAT_OK) begin
          res_orig_d = rd_q.order;
          res_key_d  = rd_q.key;
        end
      end
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= pcks_pkg::mode_e'(s_axis_tuser_i);
      px_q   <= s_axis_tdata_i[31:0];
      py_q   <= s_axis_tdata_i[63:32];
      dis_q  <= s_axis_tdata_i[64+17];
      rank_q <= s_axis_tdata_i[137:128];
      qx_q   <= s_axis_tdata_i[153:138];
    end
    prod_q <= mul_p;
    if (state_q == pcks_pkg::S_MUL_Y) xi_q <= pcks_pkg::cell_axis(prod_q);
    if (state_q == pcks_pkg::S_MUL_K) yi_q <= pcks_pkg::cell_axis(prod_q);
    if (state_q == pcks_pkg::S_SORT_HOLD) hold_q <= rd_q;
    res_orig_q  <= res_orig_d;
    res_key_q   <= res_key_d;
    res_first_q <= res_first_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    j_q     <= j_d;
    first_q <= first_d;
    len_q   <= len_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcks_pkg::S_IDLE;
      inv_q       <= pcks_pkg::InvCellReset;
      rows_q      <= pcks_pkg::GridRowsReset;
      loaded_q    <= '0;
      kept_q      <= '0;
      res_stat_q  <= pcks_pkg::STAT_OK;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
    end else begin
      state_q    <= state_d;
      res_stat_q <= res_stat_d;
      if (cfg_we_i) begin
        case (pcks_pkg::reg_e'(cfg_addr_i))
          pcks_pkg::REG_INV_CELL:  inv_q  <= cfg_wdata_i;
          pcks_pkg::REG_GRID_ROWS: rows_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (state_q == pcks_pkg::S_WR_LD) loaded_q <= loaded_q + 1'b1;
      if (state_q == pcks_pkg::S_SORT_I && idx_q >= cnt_q) begin
        loaded_q <= cnt_q;
        kept_q   <= cnt_q;
      end
      if (m_axis_tready_i) out_valid_q <= 1'b0;
      // hand the finished beat to the output register
      if (state_q == pcks_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_user_q  <= res_stat_q;
        out_data_q  <= {res_first_q, res_key_d, res_orig_d, kept_q};
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
`default_nettype wire

[sv/pcks_checker.sv]
// Port-level checker for the particle cell key sort core, bound to the top level.
// Depends on pcks_pkg.
`default_nettype none
module pcks_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [63:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // hold a stalled beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed under stall");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("undefined status code");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[10:0] <= 11'(pcks_pkg::Capacity))
    else $error("survivor count beyond capacity");

  a_bad_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == pcks_pkg::STAT_BAD_RANK |->
      m_axis_tdata_o[63:11] == '0)
    else $error("rank miss carries data");

endmodule

bind particle_cell_key_sort_core pcks_props u_pcks_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire
